// ===== rtl/folo_pkg.sv =====
// Shared types and constants for the frequency-ordered lookup table.
// Holds the request and response words, the action and status codes and
// the per-cell select code. No dependencies.
package folo_pkg;

   localparam int KEY_W   = 32;
   localparam int POS_W   = 4;
   localparam int FREQ_W  = 16;
   localparam int TOTAL_W = 5;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_LOCATE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // What a cell takes into its registers in the coming cycle.
   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_LEFT  = 2'd1,
      SEL_RIGHT = 2'd2,
      SEL_LOAD  = 2'd3
   } cell_sel_type;

   typedef struct packed {
      action_type               action;
      logic signed [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    position;
      logic [FREQ_W-1:0]   frequency;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

endpackage

// ===== rtl/folo_cell.sv =====
// One slot of the table: a key and its access count, with the neighbor
// moves and the two compares that the controller needs.
// Depends on folo_pkg.
module folo_cell #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  folo_pkg::cell_sel_type        sel,
   input  logic [folo_pkg::KEY_W-1:0]    left_key,
   input  logic [COUNT_BITS-1:0]         left_count,
   input  logic [folo_pkg::KEY_W-1:0]    right_key,
   input  logic [COUNT_BITS-1:0]         right_count,
   input  logic [folo_pkg::KEY_W-1:0]    load_key,
   input  logic [COUNT_BITS-1:0]         load_count,
   input  logic [folo_pkg::KEY_W-1:0]    lookup_key,
   input  logic [COUNT_BITS-1:0]         ref_count,
   output logic [folo_pkg::KEY_W-1:0]    key_q,
   output logic [COUNT_BITS-1:0]         count_q,
   output logic                          match,
   output logic                          not_greater
);
   import folo_pkg::*;

   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      key_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   always_comb begin
      case (sel)
         SEL_LEFT: begin
            key_in   = left_key;
            count_in = left_count;
         end
         SEL_RIGHT: begin
            key_in   = right_key;
            count_in = right_count;
         end
         SEL_LOAD: begin
            key_in   = load_key;
            count_in = load_count;
         end
         default: begin
            key_in   = key_ff;
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign key_q       = key_ff;
   assign count_q     = count_ff;
   assign match       = (key_ff == lookup_key);
   assign not_greater = (count_ff <= ref_count);

endmodule

// ===== rtl/frequency_ordered_lookup_table_core.sv =====
// Top level of the frequency-ordered lookup table: a row of DEPTH cells and
// the controller that steers them. Depends on folo_pkg and folo_cell.

// Push, pop and clear: the result word is registered at the edge that accepts
// the request, and the next request may follow in the next cycle unless a
// stalled result holds it off. A result waits in an output register, so a
// stalled result holds off only the next request. Locate: all cells compare
// the key at the accepting edge, the search state picks the first matching
// cell and raises its count or reports a miss, and on a hit the move state
// finds the first cell whose count is not greater and moves every entry between
// the old and the new position by one cell, all in parallel. Each of the two
// first-one searches over the row gets a state of its own. Stored entries need
// no clearing after reset; only the state, entry count and result valid are reset.
module frequency_ordered_lookup_table_core #(
   parameter int DEPTH      = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  folo_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output folo_pkg::rsp_type rsp_data
);
   import folo_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE
   } state_type;

   state_type             state_ff, state_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [DEPTH-1:0]      match_ff, match_in;
   logic [DEPTH-1:0]      hit_oh_ff, hit_oh_in;
   logic [DEPTH-1:0]      below_hit_ff, below_hit_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic                  req_accept;
   logic                  rsp_load;

   logic [KEY_W-1:0]      cell_key   [DEPTH];
   logic [COUNT_BITS-1:0] cell_count [DEPTH];
   cell_sel_type          cell_sel   [DEPTH];
   logic [DEPTH-1:0]      cell_match;
   logic [DEPTH-1:0]      cell_ng;
   logic [KEY_W-1:0]      load_key;
   logic [COUNT_BITS-1:0] load_count;

   logic [DEPTH-1:0]      valid_mask;
   logic [DEPTH-1:0]      match_minus;
   logic [DEPTH-1:0]      hit_oh_w;
   logic [DEPTH-1:0]      below_hit_w;
   logic [COUNT_BITS-1:0] hit_count;
   logic [COUNT_BITS-1:0] hit_count_sat;

   logic [DEPTH-1:0]      le_vec;
   logic [DEPTH-1:0]      le_minus;
   logic [DEPTH-1:0]      first_le;
   logic [DEPTH-1:0]      below_le;
   logic [DEPTH-1:0]      move_oh;
   logic [DEPTH-1:0]      below_move;
   logic [IDX_W-1:0]      move_pos;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Row of cells; the first cell takes the load word as its left neighbor,
   // the last one takes itself as its right neighbor.
   for (genvar g = 0; g < DEPTH; g++) begin : gen_cell
      logic [KEY_W-1:0]      lkey, rkey;
      logic [COUNT_BITS-1:0] lcnt, rcnt;
      if (g == 0) begin : gen_first
         assign lkey = load_key;
         assign lcnt = load_count;
      end else begin : gen_inner_left
         assign lkey = cell_key[g-1];
         assign lcnt = cell_count[g-1];
      end
      if (g == DEPTH - 1) begin : gen_last
         assign rkey = cell_key[g];
         assign rcnt = cell_count[g];
      end else begin : gen_inner_right
         assign rkey = cell_key[g+1];
         assign rcnt = cell_count[g+1];
      end
      folo_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock       (clock),
         .sel         (cell_sel[g]),
         .left_key    (lkey),
         .left_count  (lcnt),
         .right_key   (rkey),
         .right_count (rcnt),
         .load_key    (load_key),
         .load_count  (load_count),
         .lookup_key  (req_data.key),
         .ref_count   (cnt_ff),
         .key_q       (cell_key[g]),
         .count_q     (cell_count[g]),
         .match       (cell_match[g]),
         .not_greater (cell_ng[g])
      );
   end

   // Occupied cells, first matching cell and its raised count.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_mask[i] = (occ_ff > OCC_W'(i));
      end
      match_minus = match_ff - DEPTH'(1);
      hit_oh_w    = match_ff & ~match_minus;
      below_hit_w = ~match_ff & match_minus;
      hit_count   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit_oh_w[i]) begin
            hit_count = hit_count | cell_count[i];
         end
      end
      hit_count_sat = (hit_count == '1) ? hit_count : hit_count + COUNT_BITS'(1);
   end

   // Insertion point among the remaining entries, in post-removal positions.
   always_comb begin
      le_vec   = valid_mask & ~hit_oh_ff & cell_ng;
      le_minus = le_vec - DEPTH'(1);
      first_le = le_vec & ~le_minus;
      below_le = ~le_vec & le_minus;
      if (le_vec == '0) begin
         // no entry is not greater: append at the tail
         move_oh    = valid_mask & ~(valid_mask >> 1);
         below_move = valid_mask >> 1;
      end else if ((first_le & below_hit_ff) != '0) begin
         move_oh    = first_le;
         below_move = below_le;
      end else begin
         move_oh    = first_le >> 1;
         below_move = below_le >> 1;
      end
      move_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (move_oh[i]) begin
            move_pos = move_pos | IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      key_in       = key_ff;
      match_in     = match_ff;
      hit_oh_in    = hit_oh_ff;
      below_hit_in = below_hit_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      load_key     = key_ff;
      load_count   = cnt_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cell_sel[i] = SEL_HOLD;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_in.status    = STAT_DONE;
               rsp_in.position  = '0;
               rsp_in.frequency = '0;
               case (req_data.action)
                  ACT_PUSH: begin
                     rsp_load = 1'b1;
                     if (occ_ff == OCC_W'(DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        load_key   = req_data.key;
                        load_count = '0;
                        for (int i = 0; i < DEPTH; i++) begin
                           cell_sel[i] = (i == 0) ? SEL_LOAD : SEL_LEFT;
                        end
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
                  ACT_POP: begin
                     rsp_load = 1'b1;
                     if (occ_ff == '0) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           cell_sel[i] = SEL_RIGHT;
                        end
                        occ_in = occ_ff - OCC_W'(1);
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_load = 1'b1;
                     occ_in   = '0;
                  end
                  ACT_LOCATE: begin
                     key_in   = req_data.key;
                     match_in = cell_match & valid_mask;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (match_ff == '0) begin
               rsp_load         = 1'b1;
               rsp_in.status    = STAT_MISS;
               rsp_in.position  = '0;
               rsp_in.frequency = '0;
               state_in         = ST_IDLE;
            end else begin
               hit_oh_in    = hit_oh_w;
               below_hit_in = below_hit_w;
               cnt_in       = hit_count_sat;
               state_in     = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // entries between the old and new place shift one cell toward the gap
            for (int i = 0; i < DEPTH; i++) begin
               if (move_oh[i]) begin
                  cell_sel[i] = SEL_LOAD;
               end else if (!below_move[i] && (below_hit_ff[i] || hit_oh_ff[i])) begin
                  cell_sel[i] = SEL_LEFT;
               end else if (!below_hit_ff[i] && below_move[i]) begin
                  cell_sel[i] = SEL_RIGHT;
               end else begin
                  cell_sel[i] = SEL_HOLD;
               end
            end
            rsp_load         = 1'b1;
            rsp_in.status    = STAT_DONE;
            rsp_in.position  = POS_W'(move_pos);
            rsp_in.frequency = FREQ_W'(cnt_ff);
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_in.entry_total = TOTAL_W'(occ_in);
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff       <= rsp_in;
      key_ff       <= key_in;
      match_ff     <= match_in;
      hit_oh_ff    <= hit_oh_in;
      below_hit_ff <= below_hit_in;
      cnt_ff       <= cnt_in;
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("entry count above table depth");

   a_move_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |-> $onehot(move_oh))
      else $error("insertion point not a single cell");

   a_move_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |=> $stable(occ_ff) && rsp_valid_ff && rsp_ff.status == STAT_DONE)
      else $error("located entry move changed count or lost its result");

   a_miss_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH && match_ff == '0 |=> rsp_valid_ff && rsp_ff.status == STAT_MISS)
      else $error("miss not reported");
`endif

endmodule

// ===== test/tb_frequency_ordered_lookup_table_core.sv =====
// Self-checking testbench for frequency_ordered_lookup_table_core: directed and
// random push, pop, clear and locate words checked against an in-bench table.
// Depends on folo_pkg and the RTL of the core.
module tb_frequency_ordered_lookup_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import folo_pkg::*;

   localparam int DEPTH          = 16;
   localparam int COUNT_BITS     = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_WORDS   = 910;
   localparam int POOL_SIZE      = 10;
   localparam int HOT_HITS       = 12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // table as the block should hold it
   logic [KEY_W-1:0]      entry_key[DEPTH];
   logic [COUNT_BITS-1:0] entry_count[DEPTH];
   int                    entry_fill = 0;

   req_type request_backlog[$];
   rsp_type pending_results[$];
   rsp_type want_rsp;
   int      words_sent = 0;
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      send_idle_pct;
   int      stall_pct;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   frequency_ordered_lookup_table_core #(
      .DEPTH(DEPTH),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // receiver idles more than the sender first, then the reverse, then neither
   assign send_idle_pct = (words_sent < 320) ? 33 : (words_sent < 640) ? 47 : 0;
   assign stall_pct     = (words_sent < 320) ? 47 : (words_sent < 640) ? 33 : 0;

   // Apply one word to the table and return the result it must produce.
   function automatic rsp_type lookup_outcome(req_type w);
      rsp_type               r;
      logic [KEY_W-1:0]      k;
      logic [COUNT_BITS-1:0] c;
      int                    hit;
      int                    dest;
      r = '0;
      r.status = STAT_DONE;
      k = w.key;
      hit = -1;
      dest = 0;
      case (w.action)
         ACT_PUSH: begin
            if (entry_fill >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = entry_fill; i > 0; i--) begin
                  entry_key[i] = entry_key[i-1];
                  entry_count[i] = entry_count[i-1];
               end
               entry_key[0] = k;
               entry_count[0] = '0;
               entry_fill++;
            end
         end
         ACT_POP: begin
            if (entry_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               for (int i = 0; i + 1 < entry_fill; i++) begin
                  entry_key[i] = entry_key[i+1];
                  entry_count[i] = entry_count[i+1];
               end
               entry_fill--;
            end
         end
         ACT_CLEAR: entry_fill = 0;
         default: begin
            // nearest match to the front wins
            for (int i = entry_fill - 1; i >= 0; i--)
               if (entry_key[i] == k) hit = i;
            if (hit < 0) begin
               r.status = STAT_MISS;
            end else begin
               c = entry_count[hit];
               if (c != '1) c++;
               for (int i = hit; i + 1 < entry_fill; i++) begin
                  entry_key[i] = entry_key[i+1];
                  entry_count[i] = entry_count[i+1];
               end
               // first remaining entry not above the new count, else the tail
               dest = entry_fill - 1;
               for (int i = entry_fill - 2; i >= 0; i--)
                  if (entry_count[i] <= c) dest = i;
               for (int i = entry_fill - 1; i > dest; i--) begin
                  entry_key[i] = entry_key[i-1];
                  entry_count[i] = entry_count[i-1];
               end
               entry_key[dest] = k;
               entry_count[dest] = c;
               r.position = POS_W'(dest);
               r.frequency = c;
            end
         end
      endcase
      r.entry_total = TOTAL_W'(entry_fill);
      return r;
   endfunction

   task automatic queue_word(action_type a, logic [KEY_W-1:0] k);
      req_type w;
      w.action = a;
      w.key = k;
      request_backlog.push_back(w);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // driver: hold the word until it is taken, then fetch the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(lookup_outcome(req_data));
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= request_backlog[0];
               request_backlog.delete(0);
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: status %0d", rsp_data.status);
               mismatches++;
            end else begin
               want_rsp = pending_results[0];
               pending_results.delete(0);
               compare_field("status", 32'(want_rsp.status), 32'(rsp_data.status));
               compare_field("position", 32'(want_rsp.position), 32'(rsp_data.position));
               compare_field("frequency", 32'(want_rsp.frequency),
                             32'(rsp_data.frequency));
               compare_field("entry_total", 32'(want_rsp.entry_total),
                             32'(rsp_data.entry_total));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] hot_key;
      int               pick;

      // directed: empty cases, key extremes, duplicates, fill to full
      queue_word(ACT_POP, 32'h0);
      queue_word(ACT_LOCATE, 32'h0);
      queue_word(ACT_PUSH, 32'h8000_0000);
      queue_word(ACT_PUSH, 32'h7fff_ffff);
      queue_word(ACT_PUSH, 32'h0000_0000);
      queue_word(ACT_PUSH, 32'hffff_ffff);
      queue_word(ACT_PUSH, 32'h5555_5555);
      queue_word(ACT_PUSH, 32'haaaa_aaaa);
      queue_word(ACT_PUSH, 32'h7fff_ffff);
      queue_word(ACT_LOCATE, 32'h7fff_ffff);
      queue_word(ACT_LOCATE, 32'h8000_0000);
      queue_word(ACT_LOCATE, 32'h1234_5678);
      queue_word(ACT_POP, 32'hffff_ffff);
      for (int i = 0; i < 10; i++)
         queue_word(ACT_PUSH, 32'h100 + i);
      queue_word(ACT_PUSH, 32'hdead_beef);
      queue_word(ACT_CLEAR, 32'hffff_ffff);

      // random: keys mostly from a small pool so locates hit and duplicates form
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hffff_ffff;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom;
         if (pick < 30)
            queue_word(ACT_PUSH, k);
         else if (pick < 40)
            queue_word(ACT_POP, k);
         else if (pick < 43)
            queue_word(ACT_CLEAR, k);
         else
            queue_word(ACT_LOCATE, k);
      end

      // raise one count well above the other, then send the other key to the tail
      hot_key = $urandom;
      queue_word(ACT_CLEAR, 32'h0);
      queue_word(ACT_PUSH, ~hot_key);
      queue_word(ACT_PUSH, hot_key);
      for (int n = 0; n < HOT_HITS; n++)
         queue_word(ACT_LOCATE, hot_key);
      queue_word(ACT_LOCATE, ~hot_key);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() > 0 || req_valid || pending_results.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== frequency_ordered_lookup_table_core.f =====
rtl/folo_pkg.sv
rtl/folo_cell.sv
rtl/frequency_ordered_lookup_table_core.sv
test/tb_frequency_ordered_lookup_table_core.sv
